// ----- rtl/sim_pkg.sv -----
// ----------------------------------------------------------------------------
// sim_pkg
// shared types and constants for the sorted insert merge block
// ----------------------------------------------------------------------------
package sim_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] new_value;
    } cell_ctrl_t;

endpackage

// ----- rtl/sim_cell.sv -----
// ----------------------------------------------------------------------------
// sim_cell
// one slot of the sorting chain: compares, holds, takes from left or right
// ----------------------------------------------------------------------------
module sim_cell
(
    input  logic                                clk,
    input  sim_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic                                left_keep,
    input  logic signed [sim_pkg::DATA_W-1:0]   left_value,
    input  logic signed [sim_pkg::DATA_W-1:0]   right_value,
    output logic signed [sim_pkg::DATA_W-1:0]   value,
    output logic                                keep
);

    logic signed [sim_pkg::DATA_W-1:0] value_reg;
    logic signed [sim_pkg::DATA_W-1:0] value_next;

    // stored value smaller than the new one stays in place
    assign keep  = occupied && (value_reg < ctrl.new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (keep)
            begin
                value_next = value_reg;
            end
            else if (left_keep)
            begin
                value_next = ctrl.new_value;
            end
            else
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/sorted_insert_merge.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_merge
// streaming insertion sort of signed 32-bit words over a chain of cells
// ----------------------------------------------------------------------------
// While a set is loading, one word is taken every cycle: the new word is
// compared against all MAX_ITEMS cells at once and the chain shifts right
// behind the insertion point in the same cycle. Once the word marked tlast
// has been taken, the input is held off and the chain shifts left one cell
// per accepted output word. Words arriving while all cells are occupied are
// dropped and tuser flags every word of that set.
module sorted_insert_merge
#(
    parameter int MAX_ITEMS = sim_pkg::MAX_ITEMS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sim_pkg::DATA_W-1:0]  s_axis_tdata,   // value
    input  logic                        s_axis_tlast,   // last_of_set
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sim_pkg::DATA_W-1:0]  m_axis_tdata,   // sorted_value
    output logic                        m_axis_tlast,   // last_out
    output logic                        m_axis_tuser    // overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    sim_pkg::state_t     state_reg;
    sim_pkg::state_t     state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                flag_reg;
    logic                flag_next;

    logic                in_acc;
    logic                out_acc;
    logic                full;
    sim_pkg::cell_ctrl_t ctrl;

    logic signed [sim_pkg::DATA_W-1:0] cell_value [MAX_ITEMS];
    logic                              cell_keep  [MAX_ITEMS];
    logic                              occ        [MAX_ITEMS];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign full    = (count_reg == CNT_W'(MAX_ITEMS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sim_pkg::ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = sim_pkg::ST_EMIT;
                end
            end
            sim_pkg::ST_EMIT:
            begin
                if (out_acc && (count_reg == CNT_W'(1)))
                begin
                    state_next = sim_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sim_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;
        ctrl.insert    = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.new_value = $signed(s_axis_tdata);
        count_next     = count_reg;
        flag_next      = flag_reg;
        case (state_reg)
            sim_pkg::ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_acc)
                begin
                    if (full)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
            end
            sim_pkg::ST_EMIT:
            begin
                m_axis_tvalid = (count_reg != '0);
                if (out_acc)
                begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        flag_next = 1'b0;
                    end
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sim_pkg::ST_LOAD;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic                              lk;
            logic signed [sim_pkg::DATA_W-1:0] lv;
            logic signed [sim_pkg::DATA_W-1:0] rv;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign lk = 1'b1;
                assign lv = cell_value[i];
            end
            else
            begin : g_body
                assign lk = cell_keep[i-1];
                assign lv = cell_value[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_tail
                assign rv = cell_value[i];
            end
            else
            begin : g_next
                assign rv = cell_value[i+1];
            end

            sim_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ[i]),
                .left_keep   (lk),
                .left_value  (lv),
                .right_value (rv),
                .value       (cell_value[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    assign m_axis_tdata = cell_value[0];
    assign m_axis_tlast = (count_reg == CNT_W'(1));
    assign m_axis_tuser = flag_reg;

endmodule

// ----- rtl/sim_checker.sv -----
// ----------------------------------------------------------------------------
// sim_checker
// port-level checks on the sorted insert merge block
// ----------------------------------------------------------------------------
module sim_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        s_axis_tlast,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [sim_pkg::DATA_W-1:0]  m_axis_tdata,
    input  logic                        m_axis_tlast,
    input  logic                        m_axis_tuser
);

    // loading and draining never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output valid");

    // a closing word starts the drain at once
    a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("no output after closing word");

    // after the final word of a run, input opens again
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after run");

    // overflow flag is constant through a run
    a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser))))
        else $error("overflow flag changed within a run");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind sorted_insert_merge sim_checker u_sim_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
